[rtl/blob_track_associator_defines.svh]
// Assertion macros used by the checker file.
`ifndef BLOB_TRACK_ASSOCIATOR_DEFINES_SVH
`define BLOB_TRACK_ASSOCIATOR_DEFINES_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define BTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Asserts that an antecedent implies a consequent in the next cycle.
`define BTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/bta_pkg.sv]
`default_nettype none
package bta_pkg;
	localparam int TrackSlots = 16;
	localparam int CandSlots = 16;
	localparam int CoordBits = 12;
	localparam int NumRegs = 8;

	localparam logic [2:0] RegMerge = 3'd0;
	localparam logic [2:0] RegGain = 3'd1;
	localparam logic [2:0] RegFilter = 3'd2;
	localparam logic [2:0] RegConfirm = 3'd3;
	localparam logic [2:0] RegGraceOn = 3'd4;
	localparam logic [2:0] RegGrace = 3'd5;
	localparam logic [2:0] RegLowest = 3'd6;
	localparam logic [2:0] RegMaxId = 3'd7;

	localparam logic KindDetect = 1'b0;
	localparam logic KindFrameEnd = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [31:0] time_ms;
	} in_item_t;

	typedef struct packed {
		logic [15:0] track_id;
		logic [11:0] track_x;
		logic [11:0] track_y;
		logic        no_tracks;
		logic        last;
	} out_item_t;
endpackage
`default_nettype wire

[rtl/blob_track_associator.sv]
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | bta_pkg::in_item_t
// out     | output    | out_valid/out_ready| bta_pkg::out_item_t
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// A detection scans the tracks, then the candidates when filtering and no track matched.
// A frame end ages the candidates when filtering, then the tracks, closing the gap when an
// entry leaves, then probes IDs for unnamed tracks against every slot and lists the tracks.
// The shared distance and compare unit is the rate limit; in_ready is low while busy.
// Reset clears the entry counts and ID counter and sets the registers to their defaults;
// tables need no clearing. A stalled output holds the sequencer until the transaction completes.
`default_nettype none
module blob_track_associator #(
	parameter int TRACK_SLOTS = bta_pkg::TrackSlots,
	parameter int CAND_SLOTS = bta_pkg::CandSlots,
	parameter int COORD_BITS = bta_pkg::CoordBits
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire bta_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output bta_pkg::out_item_t      out_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	import bta_pkg::*;

	localparam int TW = $clog2(TRACK_SLOTS + 1);
	localparam int CW = $clog2(CAND_SLOTS + 1);
	localparam int TI = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
	localparam int CI = (CAND_SLOTS > 1) ? $clog2(CAND_SLOTS) : 1;
	localparam int SW = (TW > CW) ? TW : CW;

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_TSCAN  = 13'b0000000000010,
		S_TUPD   = 13'b0000000000100,
		S_CSCAN  = 13'b0000000001000,
		S_CUPD   = 13'b0000000010000,
		S_CAGE   = 13'b0000000100000,
		S_CSHIFT = 13'b0000001000000,
		S_TAGE   = 13'b0000010000000,
		S_TSHIFT = 13'b0000100000000,
		S_IDSEL  = 13'b0001000000000,
		S_IDPROB = 13'b0010000000000,
		S_LIST   = 13'b0100000000000,
		S_EMPTY  = 13'b1000000000000
	} state_t;

	state_t state_q;

	logic [11:0] merge_q;
	logic [8:0]  gain_q;
	logic        filter_q, grace_on_q, lowest_q;
	logic [31:0] confirm_q, grace_q;
	logic [15:0] max_id_q;

	logic [COORD_BITS-1:0] trk_x_q [TRACK_SLOTS];
	logic [COORD_BITS-1:0] trk_y_q [TRACK_SLOTS];
	logic [31:0] trk_seen_q [TRACK_SLOTS];
	logic [15:0] trk_ident_q [TRACK_SLOTS];
	logic        trk_has_q [TRACK_SLOTS];
	logic [COORD_BITS-1:0] cand_x_q [CAND_SLOTS];
	logic [COORD_BITS-1:0] cand_y_q [CAND_SLOTS];
	logic [31:0] cand_first_q [CAND_SLOTS];
	logic [31:0] cand_seen_q [CAND_SLOTS];
	logic [TW-1:0] trk_count_q;
	logic [CW-1:0] cand_count_q;
	logic [15:0] next_ident_q;

	logic [COORD_BITS-1:0] px_q, py_q;
	logic [31:0] now_q;
	logic [SW-1:0] idx_q;
	logic [SW-1:0] sh_q;
	logic [SW-1:0] best_idx_q;
	logic          best_vld_q;
	logic [2*COORD_BITS:0] best_d_q;
	logic          promote_q;
	logic [16:0]   probe_id_q;
	logic          probe_hit_q;
	logic [COORD_BITS-1:0] pr_x_q, pr_y_q;
	logic [31:0] pr_t_q;

	// Shared distance unit: one entry per cycle.
	logic [COORD_BITS-1:0] ex, ey;
	logic [COORD_BITS:0] dx, dy;
	logic [2*COORD_BITS:0] sq_dist;
	logic [23:0] lim;
	logic        hit;
	logic [TI-1:0] ti;
	logic [CI-1:0] ci;
	logic [TI-1:0] bti;
	logic [CI-1:0] bci;

	assign ti = idx_q[TI-1:0];
	assign ci = idx_q[CI-1:0];
	assign bti = best_idx_q[TI-1:0];
	assign bci = best_idx_q[CI-1:0];

	always_comb begin
		if (state_q == S_CSCAN) begin
			ex = cand_x_q[ci];
			ey = cand_y_q[ci];
		end else begin
			ex = trk_x_q[ti];
			ey = trk_y_q[ti];
		end
		dx = (ex >= px_q) ? {1'b0, ex - px_q} : {1'b0, px_q - ex};
		dy = (ey >= py_q) ? {1'b0, ey - py_q} : {1'b0, py_q - ey};
		sq_dist = (2*COORD_BITS+1)'(dx * dx) + (2*COORD_BITS+1)'(dy * dy);
		lim = 24'(merge_q) * 24'(merge_q);
		hit = ({{(2*COORD_BITS+1 > 24 ? 2*COORD_BITS+1-24 : 0){1'b0}}, lim} >
			(2*COORD_BITS+1 > 24 ? 2*COORD_BITS+1 : 24)'(sq_dist))
			&& (!best_vld_q || sq_dist < best_d_q);
	end

	logic [31:0] limit;
	assign limit = grace_on_q ? grace_q : 32'd0;

	logic [31:0] c_unseen, c_held, t_unseen;
	assign c_unseen = now_q - cand_seen_q[ci];
	assign c_held = cand_seen_q[ci] - cand_first_q[ci];
	assign t_unseen = now_q - trk_seen_q[ti];

	function automatic logic [COORD_BITS-1:0] blend(
		input logic [COORD_BITS-1:0] o, input logic [COORD_BITS-1:0] n,
		input logic [8:0] g);
		logic [COORD_BITS+9:0] s;
		begin
			s = (COORD_BITS+10)'(o * (9'd256 - g)) + (COORD_BITS+10)'(n * g);
			blend = s[COORD_BITS+7:8];
		end
	endfunction

	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !in_valid;
	assign out_valid = (state_q == S_LIST) || (state_q == S_EMPTY);

	always_comb begin
		out_data = '0;
		if (state_q == S_EMPTY) begin
			out_data.no_tracks = 1'b1;
			out_data.last = 1'b1;
		end else begin
			out_data.track_id = trk_ident_q[ti];
			out_data.track_x = 12'(trk_x_q[ti]);
			out_data.track_y = 12'(trk_y_q[ti]);
			out_data.last = (SW'(trk_count_q) == idx_q + SW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_q <= 12'd100;
			gain_q <= 9'd256;
			filter_q <= 1'b1;
			confirm_q <= 32'd500;
			grace_on_q <= 1'b1;
			grace_q <= 32'd500;
			lowest_q <= 1'b0;
			max_id_q <= 16'd9999;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegMerge: merge_q <= cfg_data[11:0];
				RegGain: gain_q <= cfg_data[8:0];
				RegFilter: filter_q <= cfg_data[0];
				RegConfirm: confirm_q <= cfg_data;
				RegGraceOn: grace_on_q <= cfg_data[0];
				RegGrace: grace_q <= cfg_data;
				RegLowest: lowest_q <= cfg_data[0];
				RegMaxId: max_id_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			trk_count_q <= '0;
			cand_count_q <= '0;
			next_ident_q <= '0;
			idx_q <= '0;
			best_vld_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						px_q <= in_data.pos_x[COORD_BITS-1:0];
						py_q <= in_data.pos_y[COORD_BITS-1:0];
						now_q <= in_data.time_ms;
						idx_q <= '0;
						best_vld_q <= 1'b0;
						if (in_data.kind == KindDetect) state_q <= S_TSCAN;
						else if (filter_q) state_q <= S_CAGE;
						else state_q <= S_TAGE;
					end
				end
				S_TSCAN: begin
					if (idx_q >= SW'(trk_count_q)) begin
						state_q <= S_TUPD;
					end else begin
						if (hit) begin
							best_vld_q <= 1'b1;
							best_d_q <= sq_dist;
							best_idx_q <= idx_q;
						end
						idx_q <= idx_q + SW'(1);
					end
				end
				S_TUPD: begin
					idx_q <= '0;
					if (best_vld_q) begin
						trk_x_q[bti] <= (gain_q >= 9'd256) ? px_q :
							blend(trk_x_q[bti], px_q, gain_q);
						trk_y_q[bti] <= (gain_q >= 9'd256) ? py_q :
							blend(trk_y_q[bti], py_q, gain_q);
						trk_seen_q[bti] <= now_q;
						state_q <= S_IDLE;
					end else if (filter_q) begin
						state_q <= S_CSCAN;
					end else begin
						if (trk_count_q < TW'(TRACK_SLOTS)) begin
							trk_x_q[trk_count_q[TI-1:0]] <= px_q;
							trk_y_q[trk_count_q[TI-1:0]] <= py_q;
							trk_seen_q[trk_count_q[TI-1:0]] <= now_q;
							trk_has_q[trk_count_q[TI-1:0]] <= !lowest_q;
							trk_ident_q[trk_count_q[TI-1:0]] <= lowest_q ? 16'd0 : next_ident_q;
							if (!lowest_q) next_ident_q <= next_ident_q + 16'd1;
							trk_count_q <= trk_count_q + TW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_CSCAN: begin
					if (idx_q >= SW'(cand_count_q)) begin
						state_q <= S_CUPD;
					end else begin
						if (hit) begin
							best_vld_q <= 1'b1;
							best_d_q <= sq_dist;
							best_idx_q <= idx_q;
						end
						idx_q <= idx_q + SW'(1);
					end
				end
				S_CUPD: begin
					state_q <= S_IDLE;
					if (best_vld_q) begin
						cand_x_q[bci] <= px_q;
						cand_y_q[bci] <= py_q;
						cand_seen_q[bci] <= now_q;
					end else if (cand_count_q < CW'(CAND_SLOTS)) begin
						cand_x_q[cand_count_q[CI-1:0]] <= px_q;
						cand_y_q[cand_count_q[CI-1:0]] <= py_q;
						cand_first_q[cand_count_q[CI-1:0]] <= now_q;
						cand_seen_q[cand_count_q[CI-1:0]] <= now_q;
						cand_count_q <= cand_count_q + CW'(1);
					end
				end
				S_CAGE: begin
					if (idx_q >= SW'(cand_count_q)) begin
						idx_q <= '0;
						state_q <= S_TAGE;
					end else if (c_unseen > limit || c_held > confirm_q) begin
						promote_q <= !(c_unseen > limit);
						pr_x_q <= cand_x_q[ci];
						pr_y_q <= cand_y_q[ci];
						pr_t_q <= cand_seen_q[ci];
						sh_q <= idx_q;
						state_q <= S_CSHIFT;
					end else begin
						idx_q <= idx_q + SW'(1);
					end
				end
				S_CSHIFT: begin
					if (sh_q + SW'(1) < SW'(cand_count_q)) begin
						cand_x_q[sh_q[CI-1:0]] <= cand_x_q[CI'(sh_q + SW'(1))];
						cand_y_q[sh_q[CI-1:0]] <= cand_y_q[CI'(sh_q + SW'(1))];
						cand_first_q[sh_q[CI-1:0]] <= cand_first_q[CI'(sh_q + SW'(1))];
						cand_seen_q[sh_q[CI-1:0]] <= cand_seen_q[CI'(sh_q + SW'(1))];
						sh_q <= sh_q + SW'(1);
					end else begin
						cand_count_q <= cand_count_q - CW'(1);
						state_q <= S_CAGE;
						if (promote_q && trk_count_q < TW'(TRACK_SLOTS)) begin
							trk_x_q[trk_count_q[TI-1:0]] <= pr_x_q;
							trk_y_q[trk_count_q[TI-1:0]] <= pr_y_q;
							trk_seen_q[trk_count_q[TI-1:0]] <= pr_t_q;
							trk_has_q[trk_count_q[TI-1:0]] <= !lowest_q;
							trk_ident_q[trk_count_q[TI-1:0]] <= lowest_q ? 16'd0 : next_ident_q;
							if (!lowest_q) next_ident_q <= next_ident_q + 16'd1;
							trk_count_q <= trk_count_q + TW'(1);
						end
					end
				end
				S_TAGE: begin
					if (idx_q >= SW'(trk_count_q)) begin
						idx_q <= '0;
						state_q <= S_IDSEL;
					end else if (t_unseen > limit) begin
						promote_q <= 1'b0;
						sh_q <= idx_q;
						state_q <= S_TSHIFT;
					end else begin
						idx_q <= idx_q + SW'(1);
					end
				end
				S_TSHIFT: begin
					if (sh_q + SW'(1) < SW'(trk_count_q)) begin
						trk_x_q[sh_q[TI-1:0]] <= trk_x_q[TI'(sh_q + SW'(1))];
						trk_y_q[sh_q[TI-1:0]] <= trk_y_q[TI'(sh_q + SW'(1))];
						trk_seen_q[sh_q[TI-1:0]] <= trk_seen_q[TI'(sh_q + SW'(1))];
						trk_ident_q[sh_q[TI-1:0]] <= trk_ident_q[TI'(sh_q + SW'(1))];
						trk_has_q[sh_q[TI-1:0]] <= trk_has_q[TI'(sh_q + SW'(1))];
						sh_q <= sh_q + SW'(1);
					end else begin
						trk_count_q <= trk_count_q - TW'(1);
						state_q <= promote_q ? S_IDSEL : S_TAGE;
					end
				end
				S_IDSEL: begin
					if (idx_q >= SW'(trk_count_q)) begin
						idx_q <= '0;
						state_q <= (trk_count_q == '0) ? S_EMPTY : S_LIST;
					end else if (!trk_has_q[ti]) begin
						probe_id_q <= '0;
						probe_hit_q <= 1'b0;
						sh_q <= '0;
						state_q <= S_IDPROB;
					end else begin
						idx_q <= idx_q + SW'(1);
					end
				end
				S_IDPROB: begin
					// One slot is compared with the probed ID per cycle.
					if (sh_q >= SW'(trk_count_q)) begin
						if (probe_hit_q) begin
							probe_id_q <= probe_id_q + 17'd1;
							probe_hit_q <= 1'b0;
							sh_q <= '0;
						end else begin
							trk_ident_q[ti] <= probe_id_q[15:0];
							trk_has_q[ti] <= 1'b1;
							if (probe_id_q > {1'b0, max_id_q}) begin
								promote_q <= 1'b1;
								sh_q <= idx_q;
								state_q <= S_TSHIFT;
							end else begin
								idx_q <= idx_q + SW'(1);
								state_q <= S_IDSEL;
							end
						end
					end else begin
						if (trk_has_q[sh_q[TI-1:0]] &&
							{1'b0, trk_ident_q[sh_q[TI-1:0]]} == probe_id_q)
							probe_hit_q <= 1'b1;
						sh_q <= sh_q + SW'(1);
					end
				end
				S_LIST: begin
					if (out_ready) begin
						if (idx_q + SW'(1) >= SW'(trk_count_q)) state_q <= S_IDLE;
						idx_q <= idx_q + SW'(1);
					end
				end
				S_EMPTY: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/bta_checker.sv]
`default_nettype none
`include "blob_track_associator_defines.svh"
module bta_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire bta_pkg::out_item_t out_data,
	input wire logic               cfg_valid,
	input wire logic               cfg_ready
);
	`BTA_ASSERT_IMP(a_no_accept_while_out, clk, arst_n, out_valid, !in_ready)
	`BTA_ASSERT_IMP(a_empty_is_last, clk, arst_n, out_valid && out_data.no_tracks,
		out_data.last && out_data.track_id == 16'd0)
	`BTA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`BTA_ASSERT_NEXT(a_out_holds, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_data))
	`BTA_ASSERT_IMP(a_cfg_only_idle, clk, arst_n, cfg_valid && cfg_ready, !out_valid)
endmodule

bind blob_track_associator bta_checker u_bta_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
	.cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
`default_nettype wire

[test/blob_track_associator_tb.sv]
`default_nettype none
module blob_track_associator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bta_pkg::*;

	localparam int SettleCycles = 400;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	blob_track_associator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Register shadows.
	bit [11:0] merge_dist;
	bit [8:0] gain;
	bit filter_on;
	bit [31:0] confirm_ms;
	bit grace_enable;
	bit [31:0] grace_ms;
	bit lowest_mode;
	bit [15:0] id_ceiling;

	// Shadow track and candidate tables.
	bit [11:0] track_col[TrackSlots];
	bit [11:0] track_row[TrackSlots];
	bit [31:0] track_stamp[TrackSlots];
	bit [15:0] track_ident[TrackSlots];
	bit track_named[TrackSlots];
	int track_total;
	bit [11:0] cand_col[CandSlots];
	bit [11:0] cand_row[CandSlots];
	bit [31:0] cand_born[CandSlots];
	bit [31:0] cand_stamp[CandSlots];
	int cand_total;
	bit [15:0] ident_counter;

	out_item_t track_list_q[$];
	int errors;
	int items_sent;
	int frames_sent;
	int listings_seen;
	int sender_idle_pct;
	int receiver_idle_pct;
	int hold_request;
	int hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("FAIL blob_track_associator");
		$finish;
	end

	function automatic int nearest_slot(input bit [11:0] xs[16], input bit [11:0] ys[16],
			input int n, input bit [11:0] px, input bit [11:0] py);
		longint lim;
		longint best;
		longint d;
		longint dx;
		longint dy;
		int sel;
		lim = longint'(merge_dist) * longint'(merge_dist);
		best = 0;
		sel = -1;
		for (int i = 0; i < n; i++) begin
			dx = longint'(xs[i]) - longint'(px);
			dy = longint'(ys[i]) - longint'(py);
			d = dx * dx + dy * dy;
			if (d < lim && (sel < 0 || d < best)) begin
				best = d;
				sel = i;
			end
		end
		return sel;
	endfunction

	function automatic bit [11:0] smooth(input bit [11:0] old, input bit [11:0] nw);
		bit [31:0] acc;
		if (gain >= 9'd256)
			return nw;
		acc = (32'(old) * (32'd256 - 32'(gain)) + 32'(nw) * 32'(gain)) >> 8;
		return acc[11:0];
	endfunction

	function automatic void remove_track(input int k);
		for (int i = k; i + 1 < track_total; i++) begin
			track_col[i] = track_col[i + 1];
			track_row[i] = track_row[i + 1];
			track_stamp[i] = track_stamp[i + 1];
			track_ident[i] = track_ident[i + 1];
			track_named[i] = track_named[i + 1];
		end
		track_total--;
	endfunction

	function automatic void remove_cand(input int k);
		for (int i = k; i + 1 < cand_total; i++) begin
			cand_col[i] = cand_col[i + 1];
			cand_row[i] = cand_row[i + 1];
			cand_born[i] = cand_born[i + 1];
			cand_stamp[i] = cand_stamp[i + 1];
		end
		cand_total--;
	endfunction

	function automatic void open_track(input bit [11:0] x, input bit [11:0] y,
			input bit [31:0] t);
		if (track_total >= TrackSlots)
			return;
		track_col[track_total] = x;
		track_row[track_total] = y;
		track_stamp[track_total] = t;
		if (lowest_mode) begin
			track_ident[track_total] = '0;
			track_named[track_total] = 1'b0;
		end else begin
			track_ident[track_total] = ident_counter;
			track_named[track_total] = 1'b1;
			ident_counter = ident_counter + 16'd1;
		end
		track_total++;
	endfunction

	function automatic bit ident_taken(input int id);
		for (int i = 0; i < track_total; i++)
			if (track_named[i] && int'(track_ident[i]) == id)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void set_shadow(input logic [2:0] idx, input logic [31:0] val);
		case (idx)
			RegMerge: merge_dist = val[11:0];
			RegGain: gain = val[8:0];
			RegFilter: filter_on = val[0];
			RegConfirm: confirm_ms = val;
			RegGraceOn: grace_enable = val[0];
			RegGrace: grace_ms = val;
			RegLowest: lowest_mode = val[0];
			RegMaxId: id_ceiling = val[15:0];
			default: ;
		endcase
	endfunction

	function automatic void reset_shadow();
		merge_dist = 12'd100;
		gain = 9'd256;
		filter_on = 1'b1;
		confirm_ms = 32'd500;
		grace_enable = 1'b1;
		grace_ms = 32'd500;
		lowest_mode = 1'b0;
		id_ceiling = 16'd9999;
		track_total = 0;
		cand_total = 0;
		ident_counter = '0;
	endfunction

	function automatic void predict_item(input in_item_t it);
		bit [31:0] limit;
		bit [31:0] unseen;
		bit [31:0] held;
		bit [11:0] x;
		bit [11:0] y;
		bit [31:0] t;
		int k;
		int i;
		int id;
		out_item_t o;
		limit = grace_enable ? grace_ms : 32'd0;
		if (it.kind == KindDetect) begin
			k = nearest_slot(track_col, track_row, track_total, it.pos_x, it.pos_y);
			if (k >= 0) begin
				track_col[k] = smooth(track_col[k], it.pos_x);
				track_row[k] = smooth(track_row[k], it.pos_y);
				track_stamp[k] = it.time_ms;
			end else if (filter_on) begin
				k = nearest_slot(cand_col, cand_row, cand_total, it.pos_x, it.pos_y);
				if (k >= 0) begin
					cand_col[k] = it.pos_x;
					cand_row[k] = it.pos_y;
					cand_stamp[k] = it.time_ms;
				end else if (cand_total < CandSlots) begin
					cand_col[cand_total] = it.pos_x;
					cand_row[cand_total] = it.pos_y;
					cand_born[cand_total] = it.time_ms;
					cand_stamp[cand_total] = it.time_ms;
					cand_total++;
				end
			end else begin
				open_track(it.pos_x, it.pos_y, it.time_ms);
			end
			return;
		end
		if (filter_on) begin
			i = 0;
			while (i < cand_total) begin
				unseen = it.time_ms - cand_stamp[i];
				held = cand_stamp[i] - cand_born[i];
				if (unseen > limit) begin
					remove_cand(i);
				end else if (held > confirm_ms) begin
					x = cand_col[i];
					y = cand_row[i];
					t = cand_stamp[i];
					remove_cand(i);
					open_track(x, y, t);
				end else begin
					i++;
				end
			end
		end
		i = 0;
		while (i < track_total) begin
			unseen = it.time_ms - track_stamp[i];
			if (unseen > limit)
				remove_track(i);
			else
				i++;
		end
		i = 0;
		while (i < track_total) begin
			if (!track_named[i]) begin
				id = 0;
				while (ident_taken(id))
					id++;
				track_ident[i] = id[15:0];
				track_named[i] = 1'b1;
				if (id > int'(id_ceiling)) begin
					remove_track(i);
					continue;
				end
			end
			i++;
		end
		if (track_total == 0) begin
			o = '0;
			o.no_tracks = 1'b1;
			o.last = 1'b1;
			track_list_q = {track_list_q, o};
			return;
		end
		for (int j = 0; j < track_total; j++) begin
			o.track_id = track_ident[j];
			o.track_x = track_col[j];
			o.track_y = track_row[j];
			o.no_tracks = 1'b0;
			o.last = (j + 1 == track_total);
			track_list_q = {track_list_q, o};
		end
	endfunction

	// Result checker and receiver-side flow control.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (track_list_q.size() == 0) begin
				$display("%t: unexpected transaction, expected none, actual %p", $time,
					out_data);
				errors++;
			end else begin
				want = track_list_q.pop_front();
				listings_seen++;
				if (out_data.track_id !== want.track_id) begin
					$display("%t: track_id expected %0d actual %0d", $time,
						want.track_id, out_data.track_id);
					errors++;
				end
				if (out_data.track_x !== want.track_x) begin
					$display("%t: track_x expected %0d actual %0d", $time,
						want.track_x, out_data.track_x);
					errors++;
				end
				if (out_data.track_y !== want.track_y) begin
					$display("%t: track_y expected %0d actual %0d", $time,
						want.track_y, out_data.track_y);
					errors++;
				end
				if (out_data.no_tracks !== want.no_tracks) begin
					$display("%t: no_tracks expected %0d actual %0d", $time,
						want.no_tracks, out_data.no_tracks);
					errors++;
				end
				if (out_data.last !== want.last) begin
					$display("%t: last expected %0d actual %0d", $time,
						want.last, out_data.last);
					errors++;
				end
			end
		end
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	task automatic send_item(input logic kind, input int x, input int y, input bit [31:0] t);
		in_item_t it;
		int gap;
		it.kind = kind;
		it.pos_x = x[11:0];
		it.pos_y = y[11:0];
		it.time_ms = t;
		cfg_valid <= 1'b0;
		gap = 0;
		if ($urandom_range(0, 99) < sender_idle_pct)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		predict_item(it);
		items_sent++;
		if (kind == KindFrameEnd)
			frames_sent++;
	endtask

	task automatic detect(input int x, input int y, input bit [31:0] t);
		send_item(KindDetect, x, y, t);
	endtask

	task automatic frame_end(input bit [31:0] t);
		send_item(KindFrameEnd, $urandom_range(0, 4095), $urandom_range(0, 4095), t);
	endtask

	// Lets every expected transaction arrive and the block finish any detection.
	task automatic settle();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (track_list_q.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		set_shadow(idx, val);
	endtask

	task automatic test_defaults();
		frame_end(32'd0);
		detect(0, 0, 32'd0);
		detect(4095, 4095, 32'd0);
		frame_end(32'd0);
		detect(3, 4, 32'd600);
		detect(4095, 4095, 32'd600);
		frame_end(32'd600);
		detect(4090, 4093, 32'd700);
		frame_end(32'd1300);
	endtask

	task automatic test_table_full_lowest_ids();
		settle();
		write_reg(RegFilter, 32'd0);
		write_reg(RegMerge, 32'd0);
		write_reg(RegLowest, 32'd1);
		write_reg(RegMaxId, 32'd12);
		write_reg(RegGain, 32'd0);
		for (int i = 0; i < 17; i++)
			detect(i * 240, 4095 - i * 240, 32'd5000);
		frame_end(32'd5000);
	endtask

	task automatic test_time_wrap();
		settle();
		write_reg(RegFilter, 32'd1);
		write_reg(RegMerge, 32'd4095);
		write_reg(RegGraceOn, 32'd0);
		write_reg(RegGrace, 32'hFFFF_FFFF);
		write_reg(RegConfirm, 32'd0);
		write_reg(RegLowest, 32'd0);
		write_reg(RegMaxId, 32'd65535);
		detect(100, 200, 32'hFFFF_FFF0);
		detect(110, 190, 32'h0000_0010);
		frame_end(32'h0000_0010);
		settle();
		write_reg(RegGraceOn, 32'd1);
		write_reg(RegConfirm, 32'hFFFF_FFFF);
		write_reg(RegGain, 32'd128);
		detect(500, 600, 32'h0000_0020);
		frame_end(32'h8000_0020);
	endtask

	task automatic random_config();
		settle();
		write_reg(RegMerge, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
			: $urandom_range(20, 300));
		write_reg(RegGain, $urandom_range(0, 256));
		write_reg(RegFilter, 32'($urandom_range(0, 3) != 0));
		write_reg(RegConfirm, $urandom_range(0, 800));
		write_reg(RegGraceOn, 32'($urandom_range(0, 4) != 0));
		write_reg(RegGrace, $urandom_range(100, 1000));
		write_reg(RegLowest, $urandom_range(0, 1));
		write_reg(RegMaxId, ($urandom_range(0, 1) != 0) ? $urandom_range(2, 20) : 65535);
	endtask

	task automatic test_random_frames(input int item_budget);
		int ox[8];
		int oy[8];
		bit [31:0] t;
		int stop_at;
		stop_at = items_sent + item_budget;
		t = $urandom;
		for (int i = 0; i < 8; i++) begin
			ox[i] = $urandom_range(0, 4095);
			oy[i] = $urandom_range(0, 4095);
		end
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 19) == 0)
				t = $urandom;
			else
				t = t + $urandom_range(0, 400);
			for (int i = 0; i < 8; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					ox[i] = $urandom_range(0, 4095);
					oy[i] = $urandom_range(0, 4095);
				end else begin
					ox[i] = ox[i] + $urandom_range(0, 40) - 20;
					oy[i] = oy[i] + $urandom_range(0, 40) - 20;
					ox[i] = (ox[i] < 0) ? 0 : (ox[i] > 4095) ? 4095 : ox[i];
					oy[i] = (oy[i] < 0) ? 0 : (oy[i] > 4095) ? 4095 : oy[i];
				end
				if ($urandom_range(0, 2) == 0)
					detect(ox[i], oy[i], t);
			end
			if ($urandom_range(0, 2) == 0)
				detect($urandom_range(0, 4095), $urandom_range(0, 4095), t);
			frame_end(t);
		end
	endtask

	task automatic test_output_stall();
		settle();
		write_reg(RegFilter, 32'd0);
		write_reg(RegMerge, 32'd10);
		write_reg(RegGraceOn, 32'd1);
		write_reg(RegGrace, 32'd1000);
		write_reg(RegLowest, 32'd0);
		for (int i = 0; i < 16; i++)
			detect(i * 250 + 7, i * 200 + 3, 32'd100);
		hold_request = 600;
		for (int i = 0; i < 5; i++)
			frame_end(32'd100 + i);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		items_sent = 0;
		frames_sent = 0;
		listings_seen = 0;
		hold_request = 0;
		hold_left = 0;
		sender_idle_pct = 29;
		receiver_idle_pct = 55;
		reset_shadow();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_table_full_lowest_ids();
		test_time_wrap();
		random_config();
		test_random_frames(65);
		sender_idle_pct = 55;
		receiver_idle_pct = 29;
		random_config();
		test_random_frames(65);
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		random_config();
		test_random_frames(55);
		test_output_stall();
		settle();

		$display("Covered %0d items in %0d frames with %0d listed transactions,", items_sent,
			frames_sent, listings_seen);
		$display("including table overflow, ID limits, time wrap and a long output stall.");
		if (errors == 0)
			$display("PASS blob_track_associator");
		else
			$display("FAIL blob_track_associator");
		$finish;
	end
endmodule
`default_nettype wire
